/* rtl/abst_pkg.sv */
// Shared constants, types and codes for the array binary search tree key table.
package abst_pkg;

	localparam int TABLE_SLOTS = 64;
	localparam int KEY_BITS    = 16;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [KEY_BITS-1:0] key_t;

	// opcodes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_SEARCH = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_MIN    = 3'd3;
	localparam logic [2:0] OP_MAX    = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// datapath commands from the controller
	typedef struct packed {
		logic  load;      // capture opcode and key
		logic  rd_en;     // read table at rd_addr
		slot_t rd_addr;
		logic  wr_en;     // write table
		slot_t wr_addr;
		logic  wr_zero;   // write zero instead of the read key
		logic  wr_in_key; // write the input key
		logic  hold_key;  // latch the read key as carried value
	} abst_cmd_t;

	// datapath status back to the controller
	typedef struct packed {
		logic [2:0] op;
		key_t       in_key;
		key_t       rd_key;
	} abst_stat_t;

endpackage

/* rtl/abst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module abst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/abst_datapath.sv */
// Datapath: key table memory with valid bits, input capture and carried key.
module abst_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           in_op,
	input  abst_pkg::key_t       in_key,
	input  abst_pkg::abst_cmd_t  cmd,
	output abst_pkg::abst_stat_t stat
);

	logic [2:0]                    op_q;
	abst_pkg::key_t                key_q;
	abst_pkg::key_t                ram_rd;
	abst_pkg::key_t                wr_data;
	abst_pkg::key_t                carry_q;
	logic [abst_pkg::TABLE_SLOTS-1:0] valid_q;
	logic                          rd_valid_q;

	// capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			key_q <= in_key;
		end
		if (cmd.hold_key)
			carry_q <= stat.rd_key;
	end

	always_comb begin
		if (cmd.wr_zero)
			wr_data = '0;
		else if (cmd.wr_in_key)
			wr_data = key_q;
		else
			wr_data = carry_q;
	end

	// slot valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_en)
				valid_q[cmd.wr_addr] <= 1'b1;
			if (cmd.rd_en)
				rd_valid_q <= valid_q[cmd.rd_addr];
		end
	end

	abst_ram #(.WIDTH(abst_pkg::KEY_BITS), .DEPTH(abst_pkg::TABLE_SLOTS)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (cmd.wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (cmd.rd_addr),
		.rd_data (ram_rd)
	);

	assign stat.op     = op_q;
	assign stat.in_key = key_q;
	assign stat.rd_key = rd_valid_q ? ram_rd : '0;

endmodule

/* rtl/abst_ctrl.sv */
// Controller: walks the tree with one registered memory read and one check per level, and sequences deletes.
module abst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [1:0]           res_status,
	output abst_pkg::slot_t      res_slot,
	output abst_pkg::key_t       res_key,
	output abst_pkg::abst_cmd_t  cmd,
	input  abst_pkg::abst_stat_t stat
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;  // read issued for pos_q
	localparam logic [3:0] S_WCHK  = 4'd3;  // data for pos_q available
	localparam logic [3:0] S_DCHR  = 4'd4;  // delete: right child read
	localparam logic [3:0] S_DCHL  = 4'd5;  // delete: left child read
	localparam logic [3:0] S_DDSC  = 4'd6;  // delete: descend read issued
	localparam logic [3:0] S_DDCK  = 4'd7;  // delete: descend check
	localparam logic [3:0] S_DCLR  = 4'd8;  // delete: clear the final leaf
	localparam logic [3:0] S_DCPW  = 4'd9;  // delete: copy write
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_DRCK  = 4'd11; // delete: check right result
	localparam logic [3:0] S_DLCK  = 4'd12; // delete: check left result

	localparam int PW = abst_pkg::SLOT_W + 1;

	logic [3:0]      state_q;
	logic [PW-1:0]   pos_q;    // walk position, one bit wider to see overflow
	logic [PW-1:0]   m_q;      // delete: candidate extreme slot
	logic            side_q;   // descend direction: 0 left, 1 right
	logic [1:0]      st_q;
	abst_pkg::slot_t slot_q;
	abst_pkg::key_t  val_q;
	logic            zkey;
	logic            occ;
	logic [PW-1:0]   nxt;
	logic [PW-1:0]   kid_l;
	logic [PW-1:0]   kid_r;
	logic [PW-1:0]   kid_m;

	assign zkey  = (stat.in_key == '0);
	assign occ   = !pos_q[PW-1] && (stat.rd_key != '0);
	assign kid_l = {pos_q[PW-2:0], 1'b0};
	assign kid_r = {pos_q[PW-2:0], 1'b1};
	assign kid_m = {m_q[PW-2:0], side_q};
	assign nxt   = (stat.op == abst_pkg::OP_INSERT || stat.op == abst_pkg::OP_SEARCH
		|| stat.op == abst_pkg::OP_DELETE)
		? ((stat.in_key < stat.rd_key) ? kid_l : kid_r)
		: ((stat.op == abst_pkg::OP_MIN) ? kid_l : kid_r);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_DONE);
	assign res_status = st_q;
	assign res_slot   = slot_q;
	assign res_key    = val_q;

	// memory commands
	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		case (state_q)
			S_WALK: begin
				if (!pos_q[PW-1]) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = pos_q[PW-2:0];
				end
			end
			S_WCHK: begin
				if (stat.op == abst_pkg::OP_INSERT && !occ && !pos_q[PW-1]) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_addr   = pos_q[PW-2:0];
					cmd.wr_in_key = 1'b1;
				end
			end
			S_DCHR: begin
				if (!kid_r[PW-1]) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = kid_r[PW-2:0];
				end
			end
			S_DCHL: begin
				if (!kid_l[PW-1]) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = kid_l[PW-2:0];
				end
			end
			S_DDSC: begin
				if (!kid_m[PW-1]) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = kid_m[PW-2:0];
				end
			end
			S_DRCK, S_DLCK, S_DDCK: begin
				// keep the key of each new candidate
				cmd.hold_key = (stat.rd_key != '0);
			end
			S_DCPW: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = pos_q[PW-2:0];
			end
			S_DCLR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = pos_q[PW-2:0];
				cmd.wr_zero = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			m_q     <= '0;
			side_q  <= 1'b0;
			st_q    <= abst_pkg::ST_MISS;
			slot_q  <= '0;
			val_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_START;
				end
				S_START: begin
					pos_q  <= PW'(1);
					st_q   <= abst_pkg::ST_MISS;
					slot_q <= '0;
					val_q  <= '0;
					if (stat.op > abst_pkg::OP_MAX || (stat.op <= abst_pkg::OP_DELETE && zkey))
						state_q <= S_DONE;
					else
						state_q <= S_WALK;
				end
				S_WALK: state_q <= S_WCHK;
				S_WCHK: begin
					if (!occ) begin
						// empty slot or off the table
						if (stat.op == abst_pkg::OP_INSERT) begin
							st_q   <= pos_q[PW-1] ? abst_pkg::ST_FULL : abst_pkg::ST_OK;
							slot_q <= pos_q[PW-1] ? '0 : pos_q[PW-2:0];
						end else if ((stat.op == abst_pkg::OP_MIN || stat.op == abst_pkg::OP_MAX)
							&& pos_q != PW'(1)) begin
							st_q <= abst_pkg::ST_OK;
						end
						state_q <= S_DONE;
					end else if ((stat.op == abst_pkg::OP_SEARCH || stat.op == abst_pkg::OP_DELETE)
						&& stat.rd_key == stat.in_key) begin
						if (stat.op == abst_pkg::OP_SEARCH) begin
							st_q    <= abst_pkg::ST_OK;
							slot_q  <= pos_q[PW-2:0];
							val_q   <= stat.in_key;
							state_q <= S_DONE;
						end else begin
							state_q <= S_DCHR;
						end
					end else begin
						// remember the last occupied slot on an extreme walk
						if (stat.op == abst_pkg::OP_MIN || stat.op == abst_pkg::OP_MAX) begin
							slot_q <= pos_q[PW-2:0];
							val_q  <= stat.rd_key;
						end
						pos_q   <= nxt;
						state_q <= S_WALK;
					end
				end
				S_DCHR: state_q <= kid_r[PW-1] ? S_DCHL : S_DRCK;
				S_DRCK: begin
					if (stat.rd_key != '0) begin
						m_q     <= kid_r;
						side_q  <= 1'b0;
						state_q <= S_DDSC;
					end else begin
						state_q <= S_DCHL;
					end
				end
				S_DCHL: state_q <= kid_l[PW-1] ? S_DCLR : S_DLCK;
				S_DLCK: begin
					if (stat.rd_key != '0) begin
						m_q     <= kid_l;
						side_q  <= 1'b1;
						state_q <= S_DDSC;
					end else begin
						state_q <= S_DCLR;
					end
				end
				S_DDSC: state_q <= kid_m[PW-1] ? S_DCPW : S_DDCK;
				S_DDCK: begin
					if (stat.rd_key != '0) begin
						m_q     <= kid_m;
						state_q <= S_DDSC;
					end else begin
						state_q <= S_DCPW;
					end
				end
				S_DCPW: begin
					// the extreme slot becomes the one to refill
					pos_q   <= m_q;
					state_q <= S_DCHR;
				end
				S_DCLR: begin
					st_q    <= abst_pkg::ST_OK;
					slot_q  <= pos_q[PW-2:0];
					val_q   <= stat.in_key;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/array_bst_key_table_top.sv */
// Top level of the array binary search tree key table.
//
// Usage: items arrive on the slave stream s_axis (tdata = opcode, key) and
// one result per item leaves on m_axis (tdata = status, slot_index,
// key_value). The tree lives in a 64-slot table, root at slot 1, children of
// slot i at 2i and 2i+1; key 0 means empty.
// Each tree level takes one registered table read and one check, for insert,
// search, minimum and maximum alike. A delete then probes the children of
// the slot, descends each nonempty subtree to its extreme slot, copies that
// key up and finally clears the last leaf. One item is in work at a time;
// s_axis_tready is high only when idle, and the next item can be taken in
// the cycle after the result leaves.
// Reset clears every slot's valid bit at once, so the table is empty
// immediately after reset; no clearing pass is needed.
// When the receiver stalls, the result holds on m_axis until taken and no
// new item is accepted meanwhile.
module array_bst_key_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [2:0] opcode, [18:3] key, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [1:0] status, [7:2] slot_index, [23:8] key_value
);

	abst_pkg::abst_cmd_t  cmd;
	abst_pkg::abst_stat_t stat;
	logic [1:0]           res_status;
	abst_pkg::slot_t      res_slot;
	abst_pkg::key_t       res_key;

	abst_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_axis_tdata[2:0]),
		.in_key    (s_axis_tdata[18:3]),
		.cmd       (cmd),
		.stat      (stat)
	);

	abst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.res_status (res_status),
		.res_slot   (res_slot),
		.res_key    (res_key),
		.cmd        (cmd),
		.stat       (stat)
	);

	assign m_axis_tdata = {res_key, res_slot, res_status};

	// a new transaction is never taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while result pending");

	// a full result never reports a slot
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] == abst_pkg::ST_FULL) |-> (m_axis_tdata[7:2] == '0))
		else $error("full status with nonzero slot");

	// a result leaves after being taken
	a_result_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
		else $error("result repeated");

endmodule

/* sim/tb.sv */
// Self-checking testbench for the array binary search tree key table.
`timescale 1ns / 100ps

module tb;

	localparam int SLOTS     = 64;
	localparam int MAX_CYCLE = 2000000;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [15:0] key_val;
	} tree_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	logic [23:0]  pending_items[$];
	tree_result_t expected_results[$];
	logic [15:0]  shadow_table[SLOTS];
	int           fail_count;
	int           cycle_count;
	int           hold_off;
	bit           calm_phase;
	bit           feed_done;
	bit           pause_req;

	array_bst_key_table_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// tree predictor helpers
	function automatic bit slot_used(int s);
		return s < SLOTS && shadow_table[s] != 16'd0;
	endfunction

	function automatic int walk_extreme(int s, int side);
		while (slot_used(2 * s + side))
			s = 2 * s + side;
		return s;
	endfunction

	function automatic int find_slot(logic [15:0] k);
		int i;
		i = 1;
		while (slot_used(i)) begin
			if (shadow_table[i] == k)
				return i;
			i = (k < shadow_table[i]) ? 2 * i : 2 * i + 1;
		end
		return 0;
	endfunction

	// apply one item to the shadow tree and return its result
	function automatic tree_result_t apply_tree_op(logic [2:0] op, logic [15:0] k);
		tree_result_t r;
		int p, m;
		r = '{abst_pkg::ST_MISS, 6'd0, 16'd0};
		if (op inside {abst_pkg::OP_INSERT, abst_pkg::OP_SEARCH, abst_pkg::OP_DELETE}
				&& k == 16'd0)
			return r;
		case (op)
			abst_pkg::OP_INSERT: begin
				p = 1;
				while (p < SLOTS && shadow_table[p] != 16'd0)
					p = (k < shadow_table[p]) ? 2 * p : 2 * p + 1;
				if (p >= SLOTS) begin
					r.status = abst_pkg::ST_FULL;
				end else begin
					shadow_table[p] = k;
					r = '{abst_pkg::ST_OK, 6'(p), 16'd0};
				end
			end
			abst_pkg::OP_SEARCH: begin
				p = find_slot(k);
				if (p != 0)
					r = '{abst_pkg::ST_OK, 6'(p), k};
			end
			abst_pkg::OP_DELETE: begin
				p = find_slot(k);
				if (p != 0) begin
					forever begin
						if (slot_used(2 * p + 1))
							m = walk_extreme(2 * p + 1, 0);
						else if (slot_used(2 * p))
							m = walk_extreme(2 * p, 1);
						else
							break;
						shadow_table[p] = shadow_table[m];
						p = m;
					end
					shadow_table[p] = 16'd0;
					r = '{abst_pkg::ST_OK, 6'(p), k};
				end
			end
			abst_pkg::OP_MIN, abst_pkg::OP_MAX: begin
				if (slot_used(1)) begin
					p = walk_extreme(1, (op == abst_pkg::OP_MIN) ? 0 : 1);
					r = '{abst_pkg::ST_OK, 6'(p), shadow_table[p]};
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [23:0] pack_item(logic [2:0] op, logic [15:0] k);
		return {5'd0, k, op};
	endfunction

	// build the stimulus
	initial begin
		logic [15:0] k;
		int          n;
		int          sel;
		logic [15:0] pool[$];

		feed_done = 1'b0;
		pause_req = 1'b0;
		// empty tree, zero key, unknown opcodes
		pending_items.push_back(pack_item(abst_pkg::OP_MIN, 16'h0));
		pending_items.push_back(pack_item(abst_pkg::OP_MAX, 16'hFFFF));
		pending_items.push_back(pack_item(abst_pkg::OP_SEARCH, 16'd5));
		pending_items.push_back(pack_item(abst_pkg::OP_DELETE, 16'd5));
		pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'd0));
		pending_items.push_back(pack_item(3'd5, 16'd7));
		pending_items.push_back(pack_item(3'd6, 16'hAAAA));
		pending_items.push_back(pack_item(3'd7, 16'h5555));
		// extremes, equal keys going right, deletes of leaf and inner nodes
		pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'h8000));
		pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'd1));
		pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'hFFFF));
		pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'h8000));
		pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'h4000));
		pending_items.push_back(pack_item(abst_pkg::OP_MIN, 16'd0));
		pending_items.push_back(pack_item(abst_pkg::OP_MAX, 16'd0));
		pending_items.push_back(pack_item(abst_pkg::OP_SEARCH, 16'h8000));
		pending_items.push_back(pack_item(abst_pkg::OP_SEARCH, 16'd0));
		pending_items.push_back(pack_item(abst_pkg::OP_DELETE, 16'd0));
		pending_items.push_back(pack_item(abst_pkg::OP_DELETE, 16'h8000));
		pending_items.push_back(pack_item(abst_pkg::OP_DELETE, 16'd1));
		pending_items.push_back(pack_item(abst_pkg::OP_DELETE, 16'd1));
		// ascending run grows a chain of right children past the end of the table
		for (int i = 0; i < 7; i++)
			pending_items.push_back(pack_item(abst_pkg::OP_INSERT, 16'(16'hFFF0 + i)));

		// random part: well-formed tree work plus some noise
		n = 0;
		while (n < 800) begin
			if (n % 200 == 100) begin
				// drain: delete every key the random part inserted, then refill
				while (pool.size() > 0) begin
					pending_items.push_back(pack_item(abst_pkg::OP_DELETE, pool.pop_front()));
					n++;
				end
			end
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				k = (($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($urandom_range(1, 64)));
				pending_items.push_back(pack_item(abst_pkg::OP_INSERT, k));
				if (k != 16'd0)
					pool.push_back(k);
			end else if (sel < 60) begin
				k = (pool.size() > 0 && $urandom_range(0, 3) != 0) ?
					pool[$urandom_range(0, pool.size() - 1)] : 16'($urandom);
				pending_items.push_back(pack_item(abst_pkg::OP_SEARCH, k));
			end else if (sel < 80) begin
				if (pool.size() > 0 && $urandom_range(0, 3) != 0) begin
					sel = $urandom_range(0, pool.size() - 1);
					k = pool[sel];
					pool.delete(sel);
				end else begin
					k = 16'($urandom);
				end
				pending_items.push_back(pack_item(abst_pkg::OP_DELETE, k));
			end else if (sel < 95) begin
				pending_items.push_back(pack_item(
					($urandom_range(0, 1) != 0) ? abst_pkg::OP_MIN : abst_pkg::OP_MAX,
					16'($urandom)));
			end else begin
				pending_items.push_back(pack_item(3'($urandom_range(5, 7)), 16'($urandom)));
			end
			n++;
		end
		feed_done = 1'b1;
	end

	// reset and end of run
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (feed_done && pending_items.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("[array_bst_key_table_top] OK");
		else
			$display("[array_bst_key_table_top] ERROR");
		$finish;
	end

	// timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLE) begin
			$display("[array_bst_key_table_top] ERROR");
			$finish;
		end
	end

	// calm stretch with no idling on either side
	always @(posedge clk)
		calm_phase <= (cycle_count > 3000 && cycle_count < 9000);

	// driver: offer items with random gaps; pause once until results drain
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(apply_tree_op(s_axis_tdata[2:0],
					s_axis_tdata[18:3]));
				if (pending_items.size() == 500)
					pause_req = 1'b1;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the offered item
			end else if (pending_items.size() > 0 &&
					!(pause_req && expected_results.size() != 0) &&
					(calm_phase || $urandom_range(0, 99) >= 21)) begin
				pause_req = 1'b0;
				s_axis_tdata  <= pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver readiness with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_off      <= 0;
		end else if (cycle_count == 1500) begin
			hold_off      <= 600;
			m_axis_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off      <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm_phase || ($urandom_range(0, 99) >= 21);
		end
	end

	// monitor: compare each result transaction against the oldest prediction
	always @(posedge clk) begin
		tree_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status  = m_axis_tdata[1:0];
			got.slot    = m_axis_tdata[7:2];
			got.key_val = m_axis_tdata[23:8];
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
				fail_count <= fail_count + 1;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.slot !== want.slot ||
						got.key_val !== want.key_val) begin
					$display("%0t: expected status %0d slot %0d key %h, got %0d %0d %h",
						$time, want.status, want.slot, want.key_val,
						got.status, got.slot, got.key_val);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++)
			shadow_table[i] = 16'd0;
	end

endmodule
